### sv/svne_pkg.sv
// shared types, widths and codes for the smooth vertex normal engine
package svne_pkg;

  localparam int IDX_W = 10;
  localparam int POS_W = 24;
  localparam int NRM_W = 16;
  localparam int ACC_W = 24;
  localparam int MUL_W = 33;
  localparam int VEC_W = 63;
  localparam int CNT_W = 6;
  localparam int OUT_LIMIT = 32767;

  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_POS_BITS = 24;
  localparam int DEF_FRAC_BITS = 14;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_TRI  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_POS_WR,
    OP_POS_RD,
    OP_DIFF,
    OP_CROSS,
    OP_ACC_RD,
    OP_ACC_LD,
    OP_MAG,
    OP_NORM,
    OP_SQ,
    OP_SQRT,
    OP_DIV,
    OP_UPD,
    OP_MARK_NONE,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [CNT_W-1:0] cnt;
    logic [1:0]      sel;
  } svne_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       idx_ok;
    logic       corners_ok;
    logic       top_zero;
    logic       top_big;
    logic       top_small;
    logic       out_free;
  } svne_sts_t;

endpackage

### sv/svne_ctrl.sv
// sequencing state machine of the smooth vertex normal engine
module svne_ctrl #(
  parameter int FRAC_BITS = svne_pkg::DEF_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  svne_pkg::svne_sts_t sts,
  output svne_pkg::svne_cmd_t cmd
);
  import svne_pkg::*;

  localparam int QW = FRAC_BITS + 1;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DISP   = 4'd1;
  localparam logic [3:0] ST_POS_RD = 4'd2;
  localparam logic [3:0] ST_DIFF   = 4'd3;
  localparam logic [3:0] ST_CROSS  = 4'd4;
  localparam logic [3:0] ST_ACC_RD = 4'd5;
  localparam logic [3:0] ST_ACC_LD = 4'd6;
  localparam logic [3:0] ST_MAG    = 4'd7;
  localparam logic [3:0] ST_NORM   = 4'd8;
  localparam logic [3:0] ST_SQ     = 4'd9;
  localparam logic [3:0] ST_SQRT   = 4'd10;
  localparam logic [3:0] ST_DIV    = 4'd11;
  localparam logic [3:0] ST_UPD    = 4'd12;
  localparam logic [3:0] ST_OUT    = 4'd13;

  localparam logic [CNT_W-1:0] CNT_POS_END   = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_CROSS_END = CNT_W'(6);
  localparam logic [CNT_W-1:0] CNT_SQ_END    = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_SQRT_END  = CNT_W'(31);
  localparam logic [CNT_W-1:0] CNT_UPD_END   = CNT_W'(5);
  localparam logic [CNT_W-1:0] CNT_DIV_END   = CNT_W'(QW + 1);
  localparam logic [1:0]       SEL_LAST      = 2'd2;

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [1:0]       sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      sel   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    sel_next   = sel;
    cmd.op     = OP_NONE;
    cmd.cnt    = cnt;
    cmd.sel    = sel;
    in_ready   = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_CAPTURE;
          state_next = ST_DISP;
        end
      end
      ST_DISP: begin
        cnt_next = '0;
        sel_next = '0;
        unique case (sts.mode)
          MODE_LOAD: begin
            if (sts.idx_ok) cmd.op = OP_POS_WR;
            state_next = ST_IDLE;
          end
          MODE_TRI: state_next = sts.corners_ok ? ST_POS_RD : ST_IDLE;
          MODE_READ: begin
            if (sts.idx_ok) begin
              state_next = ST_ACC_RD;
            end else begin
              cmd.op     = OP_MARK_NONE;
              state_next = ST_OUT;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_POS_RD: begin
        cmd.op   = OP_POS_RD;
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_POS_END) begin
          cnt_next   = '0;
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.op     = OP_DIFF;
        state_next = ST_CROSS;
      end
      ST_CROSS: begin
        cmd.op   = OP_CROSS;
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_CROSS_END) begin
          cnt_next   = '0;
          state_next = ST_MAG;
        end
      end
      ST_ACC_RD: begin
        cmd.op     = OP_ACC_RD;
        state_next = ST_ACC_LD;
      end
      ST_ACC_LD: begin
        cmd.op     = OP_ACC_LD;
        state_next = ST_MAG;
      end
      ST_MAG: begin
        cmd.op     = OP_MAG;
        state_next = ST_NORM;
      end
      ST_NORM: begin
        priority if (sts.top_zero) begin
          if (sts.mode == MODE_READ) begin
            cmd.op     = OP_MARK_NONE;
            state_next = ST_OUT;
          end else begin
            state_next = ST_IDLE;
          end
        end else if (sts.top_big || sts.top_small) begin
          cmd.op = OP_NORM;
        end else begin
          cnt_next   = '0;
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.op   = OP_SQ;
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_SQ_END) begin
          cnt_next   = '0;
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.op   = OP_SQRT;
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_SQRT_END) begin
          cnt_next   = '0;
          sel_next   = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.op   = OP_DIV;
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_DIV_END) begin
          cnt_next = '0;
          if (sel == SEL_LAST) begin
            sel_next   = '0;
            state_next = (sts.mode == MODE_TRI) ? ST_UPD : ST_OUT;
          end else begin
            sel_next = sel + 2'd1;
          end
        end
      end
      ST_UPD: begin
        cmd.op   = OP_UPD;
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_UPD_END) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.op     = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### sv/svne_dp.sv
// datapath: stores, shared multiplier, square root, divider and output register
module svne_dp #(
  parameter int MAX_VERTICES = svne_pkg::DEF_MAX_VERTICES,
  parameter int POS_BITS     = svne_pkg::DEF_POS_BITS,
  parameter int FRAC_BITS    = svne_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  svne_pkg::svne_cmd_t                 cmd,
  output svne_pkg::svne_sts_t                 sts,
  input  logic [1:0]                          mode,
  input  logic [svne_pkg::IDX_W-1:0]          vertex_index,
  input  logic signed [svne_pkg::POS_W-1:0]   pos_x,
  input  logic signed [svne_pkg::POS_W-1:0]   pos_y,
  input  logic signed [svne_pkg::POS_W-1:0]   pos_z,
  input  logic [svne_pkg::IDX_W-1:0]          corner_a,
  input  logic [svne_pkg::IDX_W-1:0]          corner_b,
  input  logic [svne_pkg::IDX_W-1:0]          corner_c,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [svne_pkg::NRM_W-1:0]   normal_x,
  output logic signed [svne_pkg::NRM_W-1:0]   normal_y,
  output logic signed [svne_pkg::NRM_W-1:0]   normal_z,
  output logic                                no_normal
);
  import svne_pkg::*;

  localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int PW  = POS_BITS;
  localparam int DSH = (POS_BITS > 30) ? POS_BITS - 30 : 0;
  localparam int QW  = FRAC_BITS + 1;
  localparam int NW  = QW + 31;

  // captured item
  logic [1:0]              mode_q;
  logic [IDX_W-1:0]        vi_q;
  logic [IDX_W-1:0]        cor [3];
  logic signed [POS_W-1:0] px_q, py_q, pz_q;

  // working registers
  logic signed [PW-1:0]    pt [3][3];
  logic signed [MUL_W-1:0] d01 [3];
  logic signed [MUL_W-1:0] d12 [3];
  logic signed [VEC_W-1:0] vec [3];
  logic [VEC_W-1:0]        mg [3];
  logic signed [VEC_W-1:0] prod;
  logic [VEC_W-1:0]        xr, rr;
  logic [31:0]             rem;
  logic [QW-1:0]           nlow;
  logic signed [NRM_W-1:0] nout [3];
  logic                    res_none;

  // stores
  logic [3*PW-1:0]    pos_mem [MAX_VERTICES];
  logic [3*ACC_W-1:0] acc_mem [MAX_VERTICES];
  logic [3*PW-1:0]    pos_rd;
  logic [3*ACC_W-1:0] acc_rd;

  function automatic logic signed [MUL_W-1:0] edge_diff(input logic signed [PW-1:0] a,
                                                         input logic signed [PW-1:0] b);
    logic signed [PW:0] d;
    logic [PW:0]        mag;
    logic [PW:0]        sm;
    d   = (PW+1)'(a) - (PW+1)'(b);
    mag = d[PW] ? unsigned'(-d) : unsigned'(d);
    sm  = mag >> DSH;
    return d[PW] ? -MUL_W'(sm) : MUL_W'(sm);
  endfunction

  // position conversion: low POS_BITS bits of the zero-extended field
  logic [31:0]    rx, ry, rz;
  logic [3*PW-1:0] pos_wd;
  assign rx = {{(32-POS_W){1'b0}}, px_q};
  assign ry = {{(32-POS_W){1'b0}}, py_q};
  assign rz = {{(32-POS_W){1'b0}}, pz_q};
  assign pos_wd = {rz[PW-1:0], ry[PW-1:0], rx[PW-1:0]};

  logic [1:0]    pos_sel;
  logic [1:0]    pidx;
  logic [AW-1:0] pos_ra;
  assign pos_sel = (cmd.cnt[1:0] == 2'd3) ? 2'd0 : cmd.cnt[1:0];
  assign pidx    = cmd.cnt[1:0] - 2'd1;
  assign pos_ra  = AW'(cor[pos_sel]);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_POS_WR) pos_mem[AW'(vi_q)] <= pos_wd;
    pos_rd <= pos_mem[pos_ra];
  end

  // accumulator store
  logic [1:0]         upd_k;
  logic               acc_we;
  logic [AW-1:0]      acc_wa, acc_ra;
  logic [3*ACC_W-1:0] acc_wd, upd_sum;
  logic signed [ACC_W:0] sat_s [3];

  assign upd_k = (cmd.cnt[2:1] == 2'd3) ? 2'd0 : cmd.cnt[2:1];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sat_s[a] = (ACC_W+1)'(signed'(acc_rd[a*ACC_W +: ACC_W])) + (ACC_W+1)'(nout[a]);
      if (sat_s[a][ACC_W] != sat_s[a][ACC_W-1])
        upd_sum[a*ACC_W +: ACC_W] = sat_s[a][ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                    : {1'b0, {(ACC_W-1){1'b1}}};
      else
        upd_sum[a*ACC_W +: ACC_W] = sat_s[a][ACC_W-1:0];
    end
  end

  assign acc_we = (cmd.op == OP_POS_WR) || ((cmd.op == OP_UPD) && cmd.cnt[0]);
  assign acc_wa = (cmd.op == OP_POS_WR) ? AW'(vi_q) : AW'(cor[upd_k]);
  assign acc_wd = (cmd.op == OP_POS_WR) ? '0 : upd_sum;
  assign acc_ra = (cmd.op == OP_UPD) ? AW'(cor[upd_k]) : AW'(vi_q);

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_wa] <= acc_wd;
    acc_rd <= acc_mem[acc_ra];
  end

  // shared multiplier, registered product
  logic signed [MUL_W-1:0]   ma, mb;
  logic signed [2*MUL_W-1:0] pfull;
  logic [1:0]                sq_k;
  assign sq_k = (cmd.cnt[1:0] == 2'd3) ? 2'd2 : cmd.cnt[1:0];

  always_comb begin
    ma = d01[1];
    mb = d12[2];
    if (cmd.op == OP_SQ) begin
      ma = signed'(MUL_W'(mg[sq_k][29:0]));
      mb = ma;
    end else begin
      unique case (cmd.cnt[2:0])
        3'd1:    begin ma = d01[2]; mb = d12[1]; end
        3'd2:    begin ma = d01[2]; mb = d12[0]; end
        3'd3:    begin ma = d01[0]; mb = d12[2]; end
        3'd4:    begin ma = d01[0]; mb = d12[1]; end
        3'd5:    begin ma = d01[1]; mb = d12[0]; end
        default: begin ma = d01[1]; mb = d12[2]; end
      endcase
    end
  end

  assign pfull = ma * mb;

  always_ff @(posedge clk) begin
    prod <= pfull[VEC_W-1:0];
  end

  logic [2:0] cross_j;
  logic [1:0] cross_c;
  assign cross_j = cmd.cnt[2:0] - 3'd1;
  assign cross_c = cross_j[2:1];

  // largest magnitude and scaling status
  logic [VEC_W-1:0] top01, top;
  logic             big4, small4;
  assign top01  = (mg[0] > mg[1]) ? mg[0] : mg[1];
  assign top    = (top01 > mg[2]) ? top01 : mg[2];
  assign big4   = |top[VEC_W-1:33];
  assign small4 = ~|top[VEC_W-1:26];

  // square root step
  logic [4:0]       sq_pos;
  logic [VEC_W-1:0] sq_bit, sq_t;
  assign sq_pos = 5'd31 - cmd.cnt[4:0];
  assign sq_bit = VEC_W'(1) << {sq_pos, 1'b0};
  assign sq_t   = rr + sq_bit;

  // divider step
  logic [NW-1:0]    div_n;
  logic [31:0]      div_d;
  logic [32:0]      div_t;
  logic             div_ge;
  logic [NRM_W-1:0] qmag;
  assign div_n  = (NW'(mg[cmd.sel][29:0]) << QW) + NW'(rr[31:0]);
  assign div_d  = {rr[30:0], 1'b0};
  assign div_t  = {rem, nlow[QW-1]};
  assign div_ge = div_t >= {1'b0, div_d};
  assign qmag   = (32'(nlow) > OUT_LIMIT) ? NRM_W'(OUT_LIMIT) : NRM_W'(nlow);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE: begin
        mode_q   <= mode;
        vi_q     <= vertex_index;
        cor[0]   <= corner_a;
        cor[1]   <= corner_b;
        cor[2]   <= corner_c;
        px_q     <= pos_x;
        py_q     <= pos_y;
        pz_q     <= pos_z;
        res_none <= 1'b0;
      end
      OP_POS_RD: begin
        if (cmd.cnt[1:0] != 2'd0)
          for (int a = 0; a < 3; a++) pt[pidx][a] <= signed'(pos_rd[a*PW +: PW]);
      end
      OP_DIFF: begin
        for (int a = 0; a < 3; a++) begin
          d01[a] <= edge_diff(pt[0][a], pt[1][a]);
          d12[a] <= edge_diff(pt[1][a], pt[2][a]);
        end
      end
      OP_CROSS: begin
        if (cmd.cnt[2:0] != 3'd0) begin
          if (!cross_j[0]) vec[cross_c] <= prod;
          else             vec[cross_c] <= vec[cross_c] - prod;
        end
      end
      OP_ACC_LD: begin
        for (int a = 0; a < 3; a++) vec[a] <= VEC_W'(signed'(acc_rd[a*ACC_W +: ACC_W]));
      end
      OP_MAG: begin
        for (int a = 0; a < 3; a++)
          mg[a] <= vec[a][VEC_W-1] ? unsigned'(-vec[a]) : unsigned'(vec[a]);
      end
      OP_NORM: begin
        for (int a = 0; a < 3; a++) begin
          if (sts.top_big) mg[a] <= big4 ? (mg[a] >> 4) : (mg[a] >> 1);
          else             mg[a] <= small4 ? (mg[a] << 4) : (mg[a] << 1);
        end
      end
      OP_SQ: begin
        unique case (cmd.cnt[1:0])
          2'd1: begin
            xr <= unsigned'(prod);
            rr <= '0;
          end
          2'd2, 2'd3: xr <= xr + unsigned'(prod);
          default: ;
        endcase
      end
      OP_SQRT: begin
        if (xr >= sq_t) begin
          xr <= xr - sq_t;
          rr <= (rr >> 1) + sq_bit;
        end else begin
          rr <= rr >> 1;
        end
      end
      OP_DIV: begin
        if (cmd.cnt == '0) begin
          rem  <= 32'(div_n[NW-1:QW]);
          nlow <= div_n[QW-1:0];
        end else if (32'(cmd.cnt) <= QW) begin
          rem  <= div_ge ? 32'(div_t - {1'b0, div_d}) : div_t[31:0];
          nlow <= {nlow[QW-2:0], div_ge};
        end else begin
          nout[cmd.sel] <= vec[cmd.sel][VEC_W-1] ? -signed'(qmag) : signed'(qmag);
        end
      end
      OP_MARK_NONE: res_none <= 1'b1;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.op == OP_OUT) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      normal_x  <= res_none ? '0 : nout[0];
      normal_y  <= res_none ? '0 : nout[1];
      normal_z  <= res_none ? '0 : nout[2];
      no_normal <= res_none;
    end
  end

  assign sts.mode       = mode_q;
  assign sts.idx_ok     = 32'(vi_q) < MAX_VERTICES;
  assign sts.corners_ok = (32'(cor[0]) < MAX_VERTICES) && (32'(cor[1]) < MAX_VERTICES)
                          && (32'(cor[2]) < MAX_VERTICES);
  assign sts.top_zero   = ~|top;
  assign sts.top_big    = |top[VEC_W-1:30];
  assign sts.top_small  = ~|top[VEC_W-1:29];
  assign sts.out_free   = !out_valid || out_ready;

endmodule

### sv/smooth_vertex_normal_engine_unit.sv
// top level of the smooth vertex normal engine
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_ready | mode, vertex_index, pos_x/y/z, corner_a/b/c
//  out     | out_valid/out_ready | normal_x/y/z (Q1.F), no_normal
//
// load (mode 0) is the shortest item; read (mode 2) and add triangle (mode 1)
// take longer, set by the 32-step square root and three divisions, plus any
// scaling steps
// one item is worked at a time; in_ready is high only while idle
// a finished normal sits in the output register, so the next item can start
// while the result transfer is still stalled
// rst is synchronous; both stores hold garbage until written, no clearing pass
module smooth_vertex_normal_engine_unit #(
  parameter int MAX_VERTICES     = svne_pkg::DEF_MAX_VERTICES,
  parameter int POS_BITS         = svne_pkg::DEF_POS_BITS,
  parameter int NORMAL_FRAC_BITS = svne_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        mode,
  input  logic [svne_pkg::IDX_W-1:0]        vertex_index,
  input  logic signed [svne_pkg::POS_W-1:0] pos_x,
  input  logic signed [svne_pkg::POS_W-1:0] pos_y,
  input  logic signed [svne_pkg::POS_W-1:0] pos_z,
  input  logic [svne_pkg::IDX_W-1:0]        corner_a,
  input  logic [svne_pkg::IDX_W-1:0]        corner_b,
  input  logic [svne_pkg::IDX_W-1:0]        corner_c,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [svne_pkg::NRM_W-1:0] normal_x,
  output logic signed [svne_pkg::NRM_W-1:0] normal_y,
  output logic signed [svne_pkg::NRM_W-1:0] normal_z,
  output logic                              no_normal
);
  import svne_pkg::*;

  svne_cmd_t cmd;
  svne_sts_t sts;

  // sequencer: one state per phase, counters for iterative phases
  svne_ctrl #(
    .FRAC_BITS(NORMAL_FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // stores, shared multiplier, root/divide units and result register
  svne_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .POS_BITS     (POS_BITS),
    .FRAC_BITS    (NORMAL_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .mode         (mode),
    .vertex_index (vertex_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .corner_a     (corner_a),
    .corner_b     (corner_b),
    .corner_c     (corner_c),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .no_normal    (no_normal)
  );

  // an input transfer always leads into dispatch, never straight back to idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("engine ready right after an input transfer");

  // the result register is only reloaded once its previous contents can leave
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT) |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  // a missing normal is reported as the zero vector
  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && no_normal) |-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
    else $error("no_normal result carries a nonzero vector");

endmodule
